// File: sv/ptb_pkg.sv
// Shared types and constants for the planar tile blitter.
// No dependencies.
package ptb_pkg;

   localparam int TILE_EDGE     = 8;
   localparam int EDGE_BITS     = $clog2(TILE_EDGE);
   localparam int TILE_MEM_DEPTH = 4096;
   localparam int INDEX_BITS    = 14;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_DRAW  = 2'd1,
      KIND_READ  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_CLEAR  = 10'b00_0000_0010,
      ST_MOD    = 10'b00_0000_0100,
      ST_LO     = 10'b00_0000_1000,
      ST_HI     = 10'b00_0001_0000,
      ST_CAP    = 10'b00_0010_0000,
      ST_PIX    = 10'b00_0100_0000,
      ST_RD     = 10'b00_1000_0000,
      ST_RDWAIT = 10'b01_0000_0000,
      ST_DONE   = 10'b10_0000_0000
   } state_type;

endpackage

// File: sv/ptb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ptb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/planar_tile_blitter_top.sv
// Planar 2bpp tile blitter: tile memory, frame buffer and the draw sequencer.
// Depends on ptb_pkg and ptb_ram.
//
// Usage
//  - Request channel (req_*): valid/stall. One request at a time; req_stall
//    is high whenever the sequencer is busy. req_kind selects: write a tile
//    pattern byte, draw an 8x8 tile, read one frame-buffer pixel, or clear
//    the frame buffer.
//  - Response channel (rsp_*): valid/stall, exactly one response per request,
//    held in an output register. A new request is taken while a response
//    still waits there; a second finished response waits in the sequencer
//    until the output register frees, and req_stall stays high meanwhile.
//  - Sequencing: a tile byte write and an off-screen draw or read go straight
//    to ST_DONE; a pixel read passes ST_RD and ST_RDWAIT, which captures the
//    frame-buffer read data; a draw takes the tile-index remainder in ST_MOD
//    (from the reciprocal-multiply quotient), then per visible row two
//    tile-memory reads, one capture and one pixel slot per column on the
//    frame buffer write port; a clear writes one pixel per cycle.
//  - Hand-over: the sequencer is idle again in the same cycle that rsp_valid
//    rises, and takes no new request before the last one is handed over.
//  - Reset (synchronous, active high) starts a clearing pass over all
//    SCREEN_WIDTH*SCREEN_HEIGHT pixels (23040 by default), with req_stall
//    held high. Tile memory is not initialised.
module planar_tile_blitter_top
   import ptb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 160,
   parameter int SCREEN_HEIGHT = 144,
   parameter int TILE_COUNT    = 256
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_tile_word,
   input  logic [7:0]  req_pos_y,
   input  logic [7:0]  req_pos_x,
   input  logic [5:0]  req_palette,
   input  logic [1:0]  req_attributes,
   input  logic [11:0] req_byte_address,
   input  logic [7:0]  req_byte_value,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_pixel_value,
   output logic        rsp_out_of_range
);

   localparam int FB_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int FB_AW    = $clog2(FB_DEPTH);
   localparam int TM_AW    = $clog2(TILE_MEM_DEPTH);
   // quotient by TILE_COUNT as (index * RECIP) >> RECIP_SHIFT, exact for 14-bit indexes
   localparam int RECIP_SHIFT = INDEX_BITS + $clog2(TILE_COUNT);
   localparam int RECIP_BITS  = INDEX_BITS + 2;
   localparam int PROD_BITS   = INDEX_BITS + RECIP_BITS;
   localparam longint RECIP   = ((longint'(1) << RECIP_SHIFT) + longint'(TILE_COUNT) - 1) /
                                longint'(TILE_COUNT);

   // control state
   state_type state_ff, state_in;
   logic [FB_AW-1:0] clr_ff, clr_in;
   logic clr_rsp_ff, clr_rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   // request context and working registers
   logic [7:0] y_ff, y_in;
   logic [7:0] x_ff, x_in;
   logic [5:0] pal_ff, pal_in;
   logic flip_x_ff, flip_x_in;
   logic flip_y_ff, flip_y_in;
   logic [EDGE_BITS-1:0] row_ff, row_in;
   logic [EDGE_BITS-1:0] col_ff, col_in;
   logic [FB_AW-1:0] row_addr_ff, row_addr_in;
   logic [7:0] lo_ff, lo_in;
   logic [7:0] hi_ff, hi_in;
   logic [INDEX_BITS-1:0] idx_ff, idx_in;
   logic [INDEX_BITS-1:0] quot_ff, quot_in;
   logic [INDEX_BITS-1:0] rem_ff, rem_in;
   logic [7:0] res_pix_ff, res_pix_in;
   logic res_oor_ff, res_oor_in;
   logic [7:0] rsp_pix_ff, rsp_pix_in;
   logic rsp_oor_ff, rsp_oor_in;

   // memory ports
   logic             tm_wr_en;
   logic [TM_AW-1:0] tm_rd_addr;
   logic [7:0]       tm_rd_data;
   logic             fb_wr_en;
   logic [FB_AW-1:0] fb_wr_addr;
   logic [7:0]       fb_wr_data;
   logic [7:0]       fb_rd_data;

   // datapath helpers
   logic                 req_acc;
   logic                 req_off;
   logic [FB_AW-1:0]     org_addr;
   logic [PROD_BITS-1:0] recip_prod;
   logic [EDGE_BITS-1:0] src_row;
   logic [EDGE_BITS-1:0] bit_idx;
   logic [1:0]           colour;
   logic                 col_vis;
   logic                 next_row_off;
   logic                 rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // off-screen test and row-major origin address
   assign req_off  = ({1'b0, req_pos_x} >= 9'(SCREEN_WIDTH)) ||
                     ({1'b0, req_pos_y} >= 9'(SCREEN_HEIGHT));
   assign org_addr = FB_AW'(32'(req_pos_y) * 32'(SCREEN_WIDTH) + 32'(req_pos_x));

   // tile-index quotient, taken at accept; remainder follows in ST_MOD
   assign recip_prod = PROD_BITS'(req_tile_word[INDEX_BITS-1:0]) * PROD_BITS'(RECIP);

   // flips: row reversal on Y, bit 7 is leftmost unless X flipped
   assign src_row = row_ff ^ {EDGE_BITS{flip_y_ff}};
   assign bit_idx = col_ff ^ {EDGE_BITS{~flip_x_ff}};
   assign colour  = {hi_ff[bit_idx], lo_ff[bit_idx]};
   assign col_vis = ({1'b0, x_ff} + 9'(col_ff)) < 9'(SCREEN_WIDTH);
   assign next_row_off = ({1'b0, y_ff} + 9'(row_ff) + 9'd1) >= 9'(SCREEN_HEIGHT);

   // tile memory: written straight from an accepted request
   assign tm_wr_en   = req_acc && (kind_type'(req_kind) == KIND_WRITE);
   assign tm_rd_addr = {rem_ff[7:0], (state_ff == ST_HI), src_row};

   // frame buffer: clearing pass or pixel plot share the write port
   always_comb begin
      fb_wr_en   = 1'b0;
      fb_wr_addr = clr_ff;
      fb_wr_data = 8'd0;
      if (state_ff == ST_CLEAR) begin
         fb_wr_en = 1'b1;
      end else if (state_ff == ST_PIX) begin
         fb_wr_en   = col_vis && (colour != 2'd0);
         fb_wr_addr = row_addr_ff + FB_AW'(col_ff);
         fb_wr_data = {pal_ff, colour};
      end
   end

   ptb_ram #(
      .WIDTH (8),
      .DEPTH (TILE_MEM_DEPTH)
   ) u_tile_mem (
      .clock   (clock),
      .wr_en   (tm_wr_en),
      .wr_addr (req_byte_address),
      .wr_data (req_byte_value),
      .rd_addr (tm_rd_addr),
      .rd_data (tm_rd_data)
   );

   ptb_ram #(
      .WIDTH (8),
      .DEPTH (FB_DEPTH)
   ) u_frame_buf (
      .clock   (clock),
      .wr_en   (fb_wr_en),
      .wr_addr (fb_wr_addr),
      .wr_data (fb_wr_data),
      .rd_addr (row_addr_ff),
      .rd_data (fb_rd_data)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      clr_rsp_in  = clr_rsp_ff;
      y_in        = y_ff;
      x_in        = x_ff;
      pal_in      = pal_ff;
      flip_x_in   = flip_x_ff;
      flip_y_in   = flip_y_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      row_addr_in = row_addr_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      idx_in      = idx_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      res_pix_in  = res_pix_ff;
      res_oor_in  = res_oor_ff;
      rsp_pix_in  = rsp_pix_ff;
      rsp_oor_in  = rsp_oor_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               res_pix_in  = 8'd0;
               res_oor_in  = 1'b0;
               y_in        = req_pos_y;
               x_in        = req_pos_x;
               pal_in      = req_palette;
               flip_x_in   = req_attributes[0] ^ req_tile_word[15];
               flip_y_in   = req_attributes[1] ^ req_tile_word[14];
               row_in      = '0;
               col_in      = '0;
               row_addr_in = org_addr;
               idx_in      = req_tile_word[INDEX_BITS-1:0];
               quot_in     = INDEX_BITS'(recip_prod >> RECIP_SHIFT);
               unique case (kind_type'(req_kind))
                  KIND_WRITE: state_in = ST_DONE;
                  KIND_DRAW: begin
                     if (req_off) begin
                        res_oor_in = 1'b1;
                        state_in   = ST_DONE;
                     end else begin
                        state_in = ST_MOD;
                     end
                  end
                  KIND_READ: begin
                     if (req_off) begin
                        res_oor_in = 1'b1;
                        state_in   = ST_DONE;
                     end else begin
                        state_in = ST_RD;
                     end
                  end
                  KIND_CLEAR: begin
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_CLEAR: begin
            clr_in = clr_ff + FB_AW'(1);
            if (clr_ff == FB_AW'(FB_DEPTH - 1)) begin
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_MOD: begin
            rem_in   = INDEX_BITS'(32'(idx_ff) - 32'(quot_ff) * 32'(TILE_COUNT));
            state_in = ST_LO;
         end
         ST_LO: state_in = ST_HI;
         ST_HI: begin
            lo_in    = tm_rd_data;
            state_in = ST_CAP;
         end
         ST_CAP: begin
            hi_in    = tm_rd_data;
            col_in   = '0;
            state_in = ST_PIX;
         end
         ST_PIX: begin
            col_in = col_ff + EDGE_BITS'(1);
            if (col_ff == EDGE_BITS'(TILE_EDGE - 1)) begin
               row_in      = row_ff + EDGE_BITS'(1);
               row_addr_in = row_addr_ff + FB_AW'(SCREEN_WIDTH);
               if (row_ff == EDGE_BITS'(TILE_EDGE - 1) || next_row_off) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_LO;
               end
            end
         end
         ST_RD: state_in = ST_RDWAIT;
         ST_RDWAIT: begin
            res_pix_in = fb_rd_data;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = res_pix_ff;
               rsp_oor_in   = res_oor_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff        <= y_in;
      x_ff        <= x_in;
      pal_ff      <= pal_in;
      flip_x_ff   <= flip_x_in;
      flip_y_ff   <= flip_y_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      row_addr_ff <= row_addr_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      idx_ff      <= idx_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      res_pix_ff  <= res_pix_in;
      res_oor_ff  <= res_oor_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_oor_ff  <= rsp_oor_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_value  = rsp_pix_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule
